### sv/arplt_pkg.sv
package arplt_pkg;

	localparam int DEF_BUCKETS    = 128;
	localparam int DEF_WAYS       = 4;
	localparam int MAX_ADDR_BYTES = 8;

	localparam logic [15:0] PROTO_IPV4 = 16'h0800;
	localparam logic [15:0] OP_REPLY   = 16'd2;
	localparam logic [5:0]  MIN_FRAME  = 6'd8;
	localparam logic [9:0]  ARP_FIXED  = 10'd16;

	// register indexes
	localparam logic [3:0] REG_HW_TYPE    = 4'd0;
	localparam logic [3:0] REG_HW_LEN     = 4'd1;
	localparam logic [3:0] REG_RANGE_LO   = 4'd2;
	localparam logic [3:0] REG_RANGE_END  = 4'd3;
	localparam logic [3:0] REG_RANGE_ON   = 4'd4;
	localparam logic [3:0] REG_SORTED     = 4'd5;
	localparam logic [3:0] REG_HIDE_OWN   = 4'd6;
	localparam logic [3:0] REG_OWN_IP     = 4'd7;

	// result status codes
	localparam logic [3:0] STAT_DROP       = 4'd0;
	localparam logic [3:0] STAT_NOT_REPLY  = 4'd1;
	localparam logic [3:0] STAT_NEW_REPORT = 4'd2;
	localparam logic [3:0] STAT_NEW_SILENT = 4'd3;
	localparam logic [3:0] STAT_CONSISTENT = 4'd4;
	localparam logic [3:0] STAT_CONFLICT   = 4'd5;
	localparam logic [3:0] STAT_SET_FULL   = 4'd6;
	localparam logic [3:0] STAT_HIT        = 4'd7;
	localparam logic [3:0] STAT_MISS       = 4'd8;

	// classification of a queued item
	localparam logic [1:0] KIND_LOOKUP    = 2'd0;
	localparam logic [1:0] KIND_DROP      = 2'd1;
	localparam logic [1:0] KIND_NOT_REPLY = 2'd2;
	localparam logic [1:0] KIND_LEARN     = 2'd3;

	typedef struct packed {
		logic [15:0] hw_type;
		logic [3:0]  hw_len;
		logic [31:0] range_first;
		logic [31:0] range_after_last;
		logic        range_filter_on;
		logic        sorted_mode;
		logic        hide_own;
		logic [31:0] own_ip;
	} cfg_t;

	typedef struct packed {
		logic [31:0] ip;
		logic [63:0] hw;
		logic [3:0]  hw_len;
		logic [63:0] from;
		logic [3:0]  from_len;
	} slot_t;

	typedef struct packed {
		logic [1:0] kind;
		logic       silent;
		slot_t      slot;
	} entry_t;

	typedef struct packed {
		logic [3:0]  status;
		logic [31:0] entry_ip;
		logic [63:0] stored_hw;
		logic [3:0]  stored_hw_len;
		logic [63:0] stored_from;
		logic [3:0]  stored_from_len;
		logic        proxied;
	} result_t;

endpackage

### sv/arp_reply_learning_table_top.sv
// channel   direction  transfer when              payload
// in        in         in_valid & !in_stall       command .. link_src_addr
// out       out        out_valid & !out_stall     status .. proxied
// cfg       in         cfg_valid & cfg_ready      cfg_index, cfg_data
//
// the front classifies an item and forms its set index over three pipeline stages
// the back takes each item through set read, way compare, resolve and write, and pops
// no new item until the last one has left resolve, held by the read-compare-write of the set rams
// after reset the fill counts of all sets are cleared with in_stall held high
// a stalled output holds its result while up to two items wait in the queue
module arp_reply_learning_table_top import arplt_pkg::*; #(
	parameter int BUCKETS = DEF_BUCKETS,
	parameter int WAYS    = DEF_WAYS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [3:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        command,
	input  logic [5:0]  frame_bytes,
	input  logic [15:0] hardware_kind,
	input  logic [15:0] protocol_kind,
	input  logic [7:0]  addr_len,
	input  logic [15:0] opcode,
	input  logic [63:0] sender_hw,
	input  logic [31:0] sender_ip,
	input  logic [3:0]  link_src_len,
	input  logic [63:0] link_src_addr,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [3:0]  status,
	output logic [31:0] entry_ip,
	output logic [63:0] stored_hw,
	output logic [3:0]  stored_hw_len,
	output logic [63:0] stored_from,
	output logic [3:0]  stored_from_len,
	output logic        proxied
);

	localparam int SET_W = $clog2(BUCKETS);
	localparam int QW    = SET_W + $bits(entry_t);

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.hw_type          <= 16'd1;
			cfg_q.hw_len           <= 4'd6;
			cfg_q.range_first      <= '0;
			cfg_q.range_after_last <= '0;
			cfg_q.range_filter_on  <= 1'b0;
			cfg_q.sorted_mode      <= 1'b0;
			cfg_q.hide_own         <= 1'b0;
			cfg_q.own_ip           <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_HW_TYPE:   cfg_q.hw_type          <= cfg_data[15:0];
				REG_HW_LEN:    cfg_q.hw_len           <= cfg_data[3:0];
				REG_RANGE_LO:  cfg_q.range_first      <= cfg_data;
				REG_RANGE_END: cfg_q.range_after_last <= cfg_data;
				REG_RANGE_ON:  cfg_q.range_filter_on  <= cfg_data[0];
				REG_SORTED:    cfg_q.sorted_mode      <= cfg_data[0];
				REG_HIDE_OWN:  cfg_q.hide_own         <= cfg_data[0];
				REG_OWN_IP:    cfg_q.own_ip           <= cfg_data;
				default: ;
			endcase
		end
	end

	logic             clearing;
	logic             push;
	logic [SET_W-1:0] push_set;
	entry_t           push_ent;
	logic             q_full;
	logic             q_empty;
	logic             q_pop;
	logic [QW-1:0]    q_rdata;
	result_t          res;

	arplt_front #(.BUCKETS(BUCKETS)) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.clearing      (clearing),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.command       (command),
		.frame_bytes   (frame_bytes),
		.hardware_kind (hardware_kind),
		.protocol_kind (protocol_kind),
		.addr_len      (addr_len),
		.opcode        (opcode),
		.sender_hw     (sender_hw),
		.sender_ip     (sender_ip),
		.link_src_len  (link_src_len),
		.link_src_addr (link_src_addr),
		.push          (push),
		.push_set      (push_set),
		.push_ent      (push_ent),
		.q_full        (q_full)
	);

	arplt_fifo #(.WIDTH(QW)) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  ({push_set, push_ent}),
		.full   (q_full),
		.pop    (q_pop),
		.rdata  (q_rdata),
		.empty  (q_empty)
	);

	arplt_back #(.BUCKETS(BUCKETS), .WAYS(WAYS)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_set     (q_rdata[QW-1 -: SET_W]),
		.q_ent     (q_rdata[$bits(entry_t)-1:0]),
		.q_pop     (q_pop),
		.clearing  (clearing),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.res       (res)
	);

	assign status          = res.status;
	assign entry_ip        = res.entry_ip;
	assign stored_hw       = res.stored_hw;
	assign stored_hw_len   = res.stored_hw_len;
	assign stored_from     = res.stored_from;
	assign stored_from_len = res.stored_from_len;
	assign proxied         = res.proxied;

endmodule

### sv/arplt_ram.sv
module arplt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

### sv/arplt_fifo.sv
module arplt_fifo #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int DEPTH = 2;
	localparam int PW    = $clog2(DEPTH);

	logic [WIDTH-1:0] buf_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [PW:0]      cnt_q;

	assign full  = (cnt_q == (PW+1)'(DEPTH));
	assign empty = (cnt_q == '0);
	assign rdata = buf_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push && !full) begin
			buf_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push && !full) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop && !empty) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push && !full, pop && !empty})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

### sv/arplt_front.sv
module arplt_front import arplt_pkg::*; #(
	parameter int BUCKETS = DEF_BUCKETS
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  cfg_t                       cfg,
	input  logic                       clearing,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic                       command,
	input  logic [5:0]                 frame_bytes,
	input  logic [15:0]                hardware_kind,
	input  logic [15:0]                protocol_kind,
	input  logic [7:0]                 addr_len,
	input  logic [15:0]                opcode,
	input  logic [63:0]                sender_hw,
	input  logic [31:0]                sender_ip,
	input  logic [3:0]                 link_src_len,
	input  logic [63:0]                link_src_addr,
	output logic                       push,
	output logic [$clog2(BUCKETS)-1:0] push_set,
	output entry_t                     push_ent,
	input  logic                       q_full
);

	localparam int SET_W = $clog2(BUCKETS);
	// floor(2^32 / BUCKETS): quotient estimate is exact or one short
	localparam logic [63:0] RECIP64 = 64'h1_0000_0000 / 64'(BUCKETS);
	localparam logic [31:0] RECIP   = RECIP64[31:0];

	typedef struct packed {
		logic        command;
		logic [5:0]  frame_bytes;
		logic [15:0] hardware_kind;
		logic [15:0] protocol_kind;
		logic [7:0]  addr_len;
		logic [15:0] opcode;
		logic [63:0] sender_hw;
		logic [31:0] sender_ip;
		logic [3:0]  link_src_len;
		logic [63:0] link_src_addr;
	} in_item_t;

	function automatic logic [63:0] byte_mask(input logic [3:0] len);
		logic [63:0] m;
		m = '0;
		for (int b = 0; b < 8; b++) begin
			if (4'(b) < len) begin
				m[63-8*b -: 8] = 8'hFF;
			end
		end
		return m;
	endfunction

	logic     v_s1, v_s2, v_s3;
	in_item_t item_s1;
	entry_t   ent_s2, ent_s3;
	logic [31:0]  q_s2;
	logic [SET_W:0] r_s3;

	logic free1, free2, free3;

	assign free3    = !v_s3 || !q_full;
	assign free2    = !v_s2 || free3;
	assign free1    = !v_s1 || free2;
	assign in_stall = clearing || !free1;

	// classification
	entry_t      ent_c;
	logic [9:0]  need_bytes;
	logic        drop_c;
	logic        ip_in_window;
	logic [31:0] last_ip;
	logic [3:0]  src_len;
	logic [63:0] prod;

	always_comb begin
		need_bytes = ARP_FIXED + {1'b0, item_s1.addr_len, 1'b0};
		drop_c = (item_s1.frame_bytes < MIN_FRAME) ||
			(item_s1.protocol_kind != PROTO_IPV4) ||
			(item_s1.hardware_kind != cfg.hw_type) ||
			(item_s1.addr_len != {4'd0, cfg.hw_len}) ||
			(item_s1.addr_len > 8'(MAX_ADDR_BYTES)) ||
			({4'd0, item_s1.frame_bytes} < need_bytes);
		src_len = (item_s1.link_src_len > 4'(MAX_ADDR_BYTES)) ?
			4'(MAX_ADDR_BYTES) : item_s1.link_src_len;
		last_ip  = cfg.range_after_last - 32'd1;
		ip_in_window = (item_s1.sender_ip >= cfg.range_first) &&
			(item_s1.sender_ip <= last_ip);

		if (item_s1.command) begin
			ent_c.kind = KIND_LOOKUP;
		end else if (drop_c) begin
			ent_c.kind = KIND_DROP;
		end else if (item_s1.opcode != OP_REPLY) begin
			ent_c.kind = KIND_NOT_REPLY;
		end else begin
			ent_c.kind = KIND_LEARN;
		end
		ent_c.silent = cfg.sorted_mode || (cfg.range_filter_on && !ip_in_window) ||
			(cfg.hide_own && (item_s1.sender_ip == cfg.own_ip));
		ent_c.slot.ip       = item_s1.sender_ip;
		ent_c.slot.hw_len   = item_s1.addr_len[3:0];
		ent_c.slot.hw       = item_s1.sender_hw & byte_mask(item_s1.addr_len[3:0]);
		ent_c.slot.from_len = src_len;
		ent_c.slot.from     = item_s1.link_src_addr & byte_mask(src_len);

		prod = {32'd0, item_s1.sender_ip} * {32'd0, RECIP};
	end

	// remainder from quotient estimate, below twice the bucket count
	logic [31:0] qb;
	logic [31:0] rem;
	assign qb  = 32'(q_s2 * 32'(BUCKETS));
	assign rem = ent_s2.slot.ip - qb;

	logic [SET_W:0] r_fix;
	assign r_fix    = (r_s3 >= (SET_W+1)'(BUCKETS)) ? r_s3 - (SET_W+1)'(BUCKETS) : r_s3;
	assign push     = v_s3 && !q_full;
	assign push_set = r_fix[SET_W-1:0];
	assign push_ent = ent_s3;

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1 <= '{command, frame_bytes, hardware_kind, protocol_kind, addr_len,
				opcode, sender_hw, sender_ip, link_src_len, link_src_addr};
		end
		if (v_s1 && free2) begin
			ent_s2 <= ent_c;
			q_s2   <= prod[63:32];
		end
		if (v_s2 && free3) begin
			ent_s3 <= ent_s2;
			r_s3   <= rem[SET_W:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (free1) begin
				v_s1 <= in_valid && !in_stall;
			end
			if (free2) begin
				v_s2 <= v_s1;
			end
			if (free3) begin
				v_s3 <= v_s2;
			end
		end
	end

endmodule

### sv/arplt_back.sv
module arplt_back import arplt_pkg::*; #(
	parameter int BUCKETS = DEF_BUCKETS,
	parameter int WAYS    = DEF_WAYS
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       q_empty,
	input  logic [$clog2(BUCKETS)-1:0] q_set,
	input  entry_t                     q_ent,
	output logic                       q_pop,
	output logic                       clearing,
	output logic                       out_valid,
	input  logic                       out_stall,
	output result_t                    res
);

	localparam int SET_W  = $clog2(BUCKETS);
	localparam int WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int CNT_W  = $clog2(WAYS + 1);
	localparam int SLOT_W = $bits(slot_t);

	localparam logic [1:0] ST_CLEAR = 2'd0;
	localparam logic [1:0] ST_IDLE  = 2'd1;
	localparam logic [1:0] ST_CMP   = 2'd2;
	localparam logic [1:0] ST_RES   = 2'd3;

	function automatic result_t fill_result(input logic [3:0] st, input slot_t s);
		result_t r;
		r.status          = st;
		r.entry_ip        = s.ip;
		r.stored_hw       = s.hw;
		r.stored_hw_len   = s.hw_len;
		r.stored_from     = s.from;
		r.stored_from_len = s.from_len;
		r.proxied         = (s.from_len != s.hw_len) || (s.from != s.hw);
		return r;
	endfunction

	logic [1:0]       state_q;
	logic [SET_W-1:0] clr_q;
	logic [SET_W-1:0] set_q;
	entry_t           cur_q;
	logic             hit_q;
	logic             full_q;
	logic [CNT_W-1:0] cnt_q;
	slot_t            sel_q;
	logic             out_valid_q;
	result_t          res_q;

	logic [SET_W-1:0] rd_addr;
	slot_t            rd_slot [WAYS];
	logic [CNT_W-1:0] cnt_rd;

	logic             out_free;
	logic             fin;
	logic             learn_new;
	result_t          res_c;

	assign clearing  = (state_q == ST_CLEAR);
	assign out_free  = !out_valid_q || !out_stall;
	assign fin       = (state_q == ST_RES) && out_free;
	assign q_pop     = (state_q == ST_IDLE) && !q_empty;
	assign rd_addr   = (state_q == ST_IDLE) ? q_set : set_q;
	assign out_valid = out_valid_q;
	assign res       = res_q;

	// one ram per way, all read at the set index together
	for (genvar w = 0; w < WAYS; w++) begin : g_way
		logic [SLOT_W-1:0] rdata_w;
		arplt_ram #(.WIDTH(SLOT_W), .DEPTH(BUCKETS)) u_ram (
			.clk   (clk),
			.we    (fin && learn_new && (cnt_q == CNT_W'(w))),
			.waddr (set_q),
			.wdata (cur_q.slot),
			.raddr (rd_addr),
			.rdata (rdata_w)
		);
		assign rd_slot[w] = rdata_w;
	end

	// ways fill in order and are never freed, so a fill count stands for valid bits
	arplt_ram #(.WIDTH(CNT_W), .DEPTH(BUCKETS)) u_cnt_ram (
		.clk   (clk),
		.we    (clearing || (fin && learn_new)),
		.waddr (clearing ? clr_q : set_q),
		.wdata (clearing ? '0 : cnt_q + 1'b1),
		.raddr (rd_addr),
		.rdata (cnt_rd)
	);

	logic  hit_c;
	slot_t sel_c;

	always_comb begin
		hit_c = 1'b0;
		sel_c = rd_slot[0];
		// lowest matching way wins
		for (int w = WAYS - 1; w >= 0; w--) begin
			if ((CNT_W'(w) < cnt_rd) && (rd_slot[w].ip == cur_q.slot.ip)) begin
				hit_c = 1'b1;
				sel_c = rd_slot[w];
			end
		end
	end

	logic same;
	assign same = (sel_q.hw_len == cur_q.slot.hw_len) && (sel_q.hw == cur_q.slot.hw) &&
		(sel_q.from_len == cur_q.slot.from_len) && (sel_q.from == cur_q.slot.from);

	always_comb begin
		learn_new = 1'b0;
		res_c = '0;
		res_c.entry_ip = cur_q.slot.ip;
		case (cur_q.kind)
			KIND_LOOKUP: begin
				if (hit_q) begin
					res_c = fill_result(STAT_HIT, sel_q);
				end else begin
					res_c.status = STAT_MISS;
				end
			end
			KIND_DROP: res_c.status = STAT_DROP;
			KIND_NOT_REPLY: res_c.status = STAT_NOT_REPLY;
			KIND_LEARN: begin
				if (hit_q) begin
					res_c = fill_result(same ? STAT_CONSISTENT : STAT_CONFLICT, sel_q);
				end else if (full_q) begin
					res_c.status = STAT_SET_FULL;
				end else begin
					learn_new = 1'b1;
					res_c = fill_result(cur_q.silent ? STAT_NEW_SILENT : STAT_NEW_REPORT,
						cur_q.slot);
				end
			end
			default: res_c.status = STAT_DROP;
		endcase
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q <= q_ent;
			set_q <= q_set;
		end
		if (state_q == ST_CMP) begin
			hit_q  <= hit_c;
			sel_q  <= sel_c;
			full_q <= (cnt_rd >= CNT_W'(WAYS));
			cnt_q  <= cnt_rd;
		end
		if (fin) begin
			res_q <= res_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (fin) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == SET_W'(BUCKETS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (q_pop) begin
						state_q <= ST_CMP;
					end
				end
				ST_CMP: state_q <= ST_RES;
				ST_RES: begin
					if (fin) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

### sv/arplt_checker.sv
module arplt_checker import arplt_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic [3:0]  status,
	input logic [31:0] entry_ip,
	input logic [63:0] stored_hw,
	input logic [3:0]  stored_hw_len,
	input logic [63:0] stored_from,
	input logic [3:0]  stored_from_len,
	input logic        proxied
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status) && $stable(entry_ip) &&
			$stable(stored_hw) && $stable(stored_from))
		else $error("stalled result changed");

	a_proxied: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> proxied == ((stored_from != stored_hw) ||
			(stored_from_len != stored_hw_len)))
		else $error("proxied flag disagrees with stored addresses");

	a_no_entry_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == STAT_DROP || status == STAT_NOT_REPLY ||
			status == STAT_SET_FULL || status == STAT_MISS) |->
			stored_hw == 64'd0 && stored_hw_len == 4'd0 && stored_from == 64'd0 &&
			stored_from_len == 4'd0 && !proxied)
		else $error("entry data shown without an entry");

endmodule

bind arp_reply_learning_table_top arplt_checker u_chk (.*);
